### design/iplc_pkg.sv
`default_nettype none

package iplc_pkg;

  // blend mode codes
  localparam logic [2:0] MODE_NORMAL     = 3'd0;
  localparam logic [2:0] MODE_BEHIND     = 3'd1;
  localparam logic [2:0] MODE_REPLACE    = 3'd2;
  localparam logic [2:0] MODE_ERASE      = 3'd3;
  localparam logic [2:0] MODE_ANTI_ERASE = 3'd4;

  // register indexes (word address)
  localparam logic [2:0] REG_BLEND_MODE      = 3'd0;
  localparam logic [2:0] REG_LAYER_OPACITY   = 3'd1;
  localparam logic [2:0] REG_AFFECT_INDEX    = 3'd2;
  localparam logic [2:0] REG_ALPHA_WR_EN     = 3'd3;
  localparam logic [2:0] REG_BASE_HAS_ALPHA  = 3'd4;
  localparam logic [2:0] REG_LAYER_HAS_ALPHA = 3'd5;
  localparam logic [2:0] REG_MASK_PRESENT    = 3'd6;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // rounding constants of the 8-bit products
  localparam logic [24:0] MUL3_ROUND = 25'h0007F5B;
  localparam logic [16:0] MUL2_ROUND = 17'h00080;
  localparam logic [7:0]  COV_THRESH = 8'd127;

  // configuration seen by the datapath
  typedef struct packed {
    logic [2:0] blend_mode;
    logic [7:0] layer_opacity;
    logic       affect_index;
    logic       alpha_wr_en;
    logic       base_has_alpha;
    logic       layer_has_alpha;
    logic       mask_present;
  } cfg_t;

  // per-item control decoded at entry
  typedef struct packed {
    logic is3;        // three-operand product
    logic nz_test;    // coverage test is nonzero instead of > 127
    logic gate;       // extra condition on the write
    logic idx_en;     // index channel may take the layer index
    logic alpha_en;   // alpha channel may take the new alpha
    logic kill_alpha; // base has no alpha: alpha forced to zero
    logic last;
  } ctl_t;

  // pixel data carried alongside the product
  typedef struct packed {
    logic [7:0] bi;
    logic [7:0] ba;
    logic [7:0] li;
    logic [7:0] aval;
  } pix_t;

endpackage

`default_nettype wire

### design/indexed_pixel_layer_compositor_core.sv
// pipeline: three register stages between input accept and output
// throughput: one item per cycle while the output is not stalled; the 8x8 and 16x8 products each take a stage
// a stall reaches the input in the same cycle only when every stage holds an item
// reset (rst, synchronous): pipeline empty, registers at their defaults
// (normal mode, opacity 255, both affect bits set, both alphas present, no mask)
`default_nettype none

module indexed_pixel_layer_compositor_core
  import iplc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        base_index,
  input  wire logic [7:0]        base_alpha,
  input  wire logic [7:0]        layer_index,
  input  wire logic [7:0]        layer_alpha,
  input  wire logic [7:0]        mask_value,
  input  wire logic              row_last,
  // output channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_index,
  output logic [7:0]             out_alpha,
  output logic                   out_row_last
);

  cfg_t cfg;

  iplc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stage registers
  logic        v1, v2, v3;
  logic        en1, en2, en3;
  ctl_t        ctl1, ctl2;
  pix_t        pix1, pix2;
  logic [15:0] p1;
  logic [23:0] q2;

  // stage enables: a stage loads when empty or when it moves on
  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // entry decode: operand selection and per-item control
  logic [7:0] m_eff, lal, mx, my;
  logic       bal_hi;
  ctl_t       ctl0;
  pix_t       pix0;

  always_comb begin
    m_eff  = cfg.mask_present ? mask_value : 8'hFF;
    lal    = cfg.layer_has_alpha ? layer_alpha : 8'hFF;
    bal_hi = cfg.base_has_alpha ? base_alpha[7] : 1'b1;

    mx             = lal;
    my             = m_eff;
    ctl0.is3       = 1'b1;
    ctl0.nz_test   = 1'b0;
    ctl0.gate      = 1'b1;
    ctl0.idx_en    = cfg.affect_index;
    ctl0.alpha_en  = cfg.alpha_wr_en;
    ctl0.kill_alpha = !cfg.base_has_alpha;
    ctl0.last      = row_last;
    pix0.bi        = base_index;
    pix0.ba        = base_alpha;
    pix0.li        = layer_index;
    pix0.aval      = 8'hFF;

    unique case (cfg.blend_mode)
      MODE_BEHIND: begin
        ctl0.gate = bal_hi;
        pix0.aval = lal;
      end
      MODE_REPLACE: begin
        mx            = m_eff;
        my            = cfg.layer_opacity;
        ctl0.is3      = 1'b0;
        ctl0.nz_test  = 1'b1;
        ctl0.alpha_en = cfg.layer_has_alpha && cfg.alpha_wr_en;
        pix0.aval     = layer_alpha;
      end
      MODE_ERASE: begin
        ctl0.idx_en   = 1'b0;
        ctl0.alpha_en = 1'b1;
        pix0.aval     = 8'h00;
      end
      MODE_ANTI_ERASE: begin
        ctl0.idx_en   = 1'b0;
        ctl0.alpha_en = 1'b1;
        pix0.aval     = 8'hFF;
      end
      default: begin
        // normal mode, also for the undefined codes
        if (!cfg.layer_has_alpha) begin
          mx       = m_eff;
          my       = cfg.layer_opacity;
          ctl0.is3 = 1'b0;
        end else if (!cfg.mask_present) begin
          mx       = layer_alpha;
          my       = cfg.layer_opacity;
          ctl0.is3 = 1'b0;
        end
      end
    endcase
  end

  // stage 1: first 8x8 product
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      p1   <= mx * my;
      ctl1 <= ctl0;
      pix1 <= pix0;
    end
  end

  // stage 2: product by opacity for the three-operand form
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      if (ctl1.is3) begin
        q2 <= p1 * cfg.layer_opacity;
      end else begin
        q2 <= {8'd0, p1};
      end
      ctl2 <= ctl1;
      pix2 <= pix1;
    end
  end

  // stage 3: rounding, threshold and channel selection
  logic [24:0] t3;
  logic [25:0] s3;
  logic [16:0] t2;
  logic [17:0] s2;
  logic [7:0]  cov;
  logic        hit, on;

  always_comb begin
    t3  = {1'b0, q2} + MUL3_ROUND;
    s3  = {1'b0, t3} + {8'd0, t3[24:7]};
    t2  = {1'b0, q2[15:0]} + MUL2_ROUND;
    s2  = {1'b0, t2} + {9'd0, t2[16:8]};
    cov = ctl2.is3 ? s3[23:16] : s2[15:8];
    hit = ctl2.nz_test ? (cov != 8'd0) : (cov > COV_THRESH);
    on  = hit && ctl2.gate;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_index    <= (on && ctl2.idx_en) ? pix2.li : pix2.bi;
      if (ctl2.kill_alpha) begin
        out_alpha <= 8'h00;
      end else begin
        out_alpha <= (on && ctl2.alpha_en) ? pix2.aval : pix2.ba;
      end
      out_row_last <= ctl2.last;
    end
  end

  assign out_valid = v3;

`ifndef SYNTHESIS
  // an empty first stage never refuses an item
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> in_ready)
    else $error("input refused while first stage empty");

  // an accepted item occupies the first stage next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v1)
    else $error("accepted item lost at first stage");

  // with no back pressure an accepted item reaches the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("item did not reach output in three cycles");
`endif

endmodule

`default_nettype wire

### design/iplc_regs.sv
`default_nettype none

module iplc_regs
  import iplc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [2:0] widx;
  logic       wr;

  assign pready = 1'b1;
  assign widx   = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blend_mode      <= MODE_NORMAL;
      cfg.layer_opacity   <= 8'hFF;
      cfg.affect_index    <= 1'b1;
      cfg.alpha_wr_en     <= 1'b1;
      cfg.base_has_alpha  <= 1'b1;
      cfg.layer_has_alpha <= 1'b1;
      cfg.mask_present    <= 1'b0;
    end else if (wr) begin
      unique case (widx)
        REG_BLEND_MODE:      cfg.blend_mode      <= pwdata[2:0];
        REG_LAYER_OPACITY:   cfg.layer_opacity   <= pwdata[7:0];
        REG_AFFECT_INDEX:    cfg.affect_index    <= pwdata[0];
        REG_ALPHA_WR_EN:     cfg.alpha_wr_en     <= pwdata[0];
        REG_BASE_HAS_ALPHA:  cfg.base_has_alpha  <= pwdata[0];
        REG_LAYER_HAS_ALPHA: cfg.layer_has_alpha <= pwdata[0];
        REG_MASK_PRESENT:    cfg.mask_present    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    prdata = '0;
    unique case (widx)
      REG_BLEND_MODE:      prdata = {29'd0, cfg.blend_mode};
      REG_LAYER_OPACITY:   prdata = {24'd0, cfg.layer_opacity};
      REG_AFFECT_INDEX:    prdata = {31'd0, cfg.affect_index};
      REG_ALPHA_WR_EN:     prdata = {31'd0, cfg.alpha_wr_en};
      REG_BASE_HAS_ALPHA:  prdata = {31'd0, cfg.base_has_alpha};
      REG_LAYER_HAS_ALPHA: prdata = {31'd0, cfg.layer_has_alpha};
      REG_MASK_PRESENT:    prdata = {31'd0, cfg.mask_present};
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### test/tb_indexed_pixel_layer_compositor_core.sv
`default_nettype none

module tb_indexed_pixel_layer_compositor_core;
  timeunit 1ns;
  timeprecision 1ps;

  import iplc_pkg::*;

  // register index past the end of the register list
  localparam logic [2:0] REG_UNMAPPED = 3'd7;
  // cycles to let the pipeline settle before a register write or the verdict
  localparam int SETTLE_CYCLES = 8;
  // byte values around the coverage threshold and the range ends
  localparam logic [7:0] EDGE_BYTES [6] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};

  typedef struct packed {
    logic [7:0] base_index;
    logic [7:0] base_alpha;
    logic [7:0] layer_index;
    logic [7:0] layer_alpha;
    logic [7:0] mask_value;
    logic       row_last;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] idx;
    logic [7:0] alpha;
    logic       row_last;
  } pixel_out_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        base_index = '0;
  logic [7:0]        base_alpha = '0;
  logic [7:0]        layer_index = '0;
  logic [7:0]        layer_alpha = '0;
  logic [7:0]        mask_value = '0;
  logic              row_last = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_index;
  logic [7:0]        out_alpha;
  logic              out_row_last;

  // shadow of the register file, at reset values
  cfg_t cfg = '{blend_mode: MODE_NORMAL, layer_opacity: 8'hFF, affect_index: 1'b1,
                alpha_wr_en: 1'b1, base_has_alpha: 1'b1, layer_has_alpha: 1'b1,
                mask_present: 1'b0};

  pixel_out_t expected_pixels [$];
  int         mismatch_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_cycles = 0;

  indexed_pixel_layer_compositor_core dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .base_index   (base_index),
    .base_alpha   (base_alpha),
    .layer_index  (layer_index),
    .layer_alpha  (layer_alpha),
    .mask_value   (mask_value),
    .row_last     (row_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_index    (out_index),
    .out_alpha    (out_alpha),
    .out_row_last (out_row_last)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // rounded 8-bit product of two bytes
  function automatic logic [7:0] product2(input logic [7:0] a, input logic [7:0] b);
    logic [31:0] t;
    t = 32'(a) * 32'(b) + 32'h80;
    return 8'(((t >> 8) + t) >> 8);
  endfunction

  // fast approximate product of three bytes
  function automatic logic [7:0] product3(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c);
    logic [31:0] t;
    t = 32'(a) * 32'(b) * 32'(c) + 32'h7F5B;
    return 8'(((t >> 7) + t) >> 16);
  endfunction

  // composited pixel for one item under configuration c
  function automatic pixel_out_t composite_pixel(input cfg_t c, input pixel_in_t p);
    pixel_out_t r;
    logic [7:0] mask;
    logic [7:0] lay_a;
    logic [7:0] base_a;
    logic [7:0] cov;
    logic       on;
    mask   = c.mask_present ? p.mask_value : 8'hFF;
    lay_a  = c.layer_has_alpha ? p.layer_alpha : 8'hFF;
    base_a = c.base_has_alpha ? p.base_alpha : 8'hFF;
    r.idx      = p.base_index;
    r.alpha    = p.base_alpha;
    r.row_last = p.row_last;
    case (c.blend_mode)
      MODE_BEHIND: begin
        cov = product3(lay_a, mask, c.layer_opacity);
        on  = (cov > COV_THRESH) && (base_a > COV_THRESH);
        if (c.affect_index && on) r.idx = p.layer_index;
        if (c.alpha_wr_en && on) r.alpha = lay_a;
      end
      MODE_REPLACE: begin
        cov = product2(mask, c.layer_opacity);
        if (c.affect_index && cov != 0) r.idx = p.layer_index;
        if (c.layer_has_alpha && c.alpha_wr_en && cov != 0) r.alpha = p.layer_alpha;
      end
      MODE_ERASE, MODE_ANTI_ERASE: begin
        if (c.base_has_alpha) begin
          cov = product3(lay_a, mask, c.layer_opacity);
          if (cov > COV_THRESH) r.alpha = (c.blend_mode == MODE_ERASE) ? 8'h00 : 8'hFF;
        end
      end
      default: begin
        // normal mode, also taken by the undefined mode codes
        if (!c.layer_has_alpha) cov = product2(mask, c.layer_opacity);
        else if (c.mask_present) cov = product3(p.layer_alpha, p.mask_value, c.layer_opacity);
        else cov = product2(p.layer_alpha, c.layer_opacity);
        on = cov > COV_THRESH;
        if (c.affect_index && on) r.idx = p.layer_index;
        if (c.alpha_wr_en && on) r.alpha = 8'hFF;
      end
    endcase
    if (!c.base_has_alpha) r.alpha = 8'h00;
    return r;
  endfunction

  // result check against the oldest expected pixel
  always @(posedge clk) begin
    pixel_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("output item with none expected: out_index %0h out_alpha %0h",
               out_index, out_alpha);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_index !== want.idx) begin
          $error("out_index expected %0h actual %0h", want.idx, out_index);
          mismatch_count++;
        end
        if (out_alpha !== want.alpha) begin
          $error("out_alpha expected %0h actual %0h", want.alpha, out_alpha);
          mismatch_count++;
        end
        if (out_row_last !== want.row_last) begin
          $error("out_row_last expected %0b actual %0b", want.row_last, out_row_last);
          mismatch_count++;
        end
      end
    end
  end

  // output ready: long hold-off when requested, else random stalls
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready = 1'b0;
      hold_cycles--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("indexed_pixel_layer_compositor_core verification failed");
    $finish;
  end

  function automatic pixel_in_t make_pixel(input logic [7:0] bi, input logic [7:0] ba,
                                           input logic [7:0] li, input logic [7:0] la,
                                           input logic [7:0] mv, input logic last);
    return '{base_index: bi, base_alpha: ba, layer_index: li, layer_alpha: la,
             mask_value: mv, row_last: last};
  endfunction

  // byte leaning toward the threshold and the range ends
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(3) == 0) return EDGE_BYTES[$urandom_range(5)];
    return 8'($urandom);
  endfunction

  function automatic pixel_in_t random_pixel();
    return make_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                      1'($urandom_range(1)));
  endfunction

  // offer one item, hold it until accepted, then maybe idle
  task automatic send_pixel(input pixel_in_t p);
    in_valid    = 1'b1;
    base_index  = p.base_index;
    base_alpha  = p.base_alpha;
    layer_index = p.layer_index;
    layer_alpha = p.layer_alpha;
    mask_value  = p.mask_value;
    row_last    = p.row_last;
    do @(posedge clk); while (!in_ready);
    expected_pixels.push_back(composite_pixel(cfg, p));
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
  endtask

  // stop sending and wait until every expected pixel has come out
  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    in_valid = 1'b0;
    @(posedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    @(negedge clk);
  endtask

  // register write over the config port, only with the pipeline empty
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    wait_idle();
    paddr   = {idx, 2'b00};
    pwdata  = value;
    pwrite  = 1'b1;
    psel    = 1'b1;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_BLEND_MODE:      cfg.blend_mode      = value[2:0];
      REG_LAYER_OPACITY:   cfg.layer_opacity   = value[7:0];
      REG_AFFECT_INDEX:    cfg.affect_index    = value[0];
      REG_ALPHA_WR_EN:     cfg.alpha_wr_en     = value[0];
      REG_BASE_HAS_ALPHA:  cfg.base_has_alpha  = value[0];
      REG_LAYER_HAS_ALPHA: cfg.layer_has_alpha = value[0];
      REG_MASK_PRESENT:    cfg.mask_present    = value[0];
      default: ;
    endcase
  endtask

  task automatic restore_defaults();
    write_reg(REG_BLEND_MODE, 32'(MODE_NORMAL));
    write_reg(REG_LAYER_OPACITY, 32'hFF);
    write_reg(REG_AFFECT_INDEX, 32'h1);
    write_reg(REG_ALPHA_WR_EN, 32'h1);
    write_reg(REG_BASE_HAS_ALPHA, 32'h1);
    write_reg(REG_LAYER_HAS_ALPHA, 32'h1);
    write_reg(REG_MASK_PRESENT, 32'h0);
  endtask

  // reset config: no mask, two-operand coverage right at the threshold
  task automatic test_reset_defaults();
    send_pixel(make_pixel(8'h12, 8'h40, 8'hAB, 8'h80, 8'h00, 1'b1));
    send_pixel(make_pixel(8'h12, 8'h40, 8'hAB, 8'h7F, 8'hFF, 1'b0));
  endtask

  // normal mode with the three-operand coverage
  task automatic test_normal_masked();
    write_reg(REG_MASK_PRESENT, 32'h1);
    send_pixel(make_pixel(8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0));
    send_pixel(make_pixel(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1));
  endtask

  // behind: base alpha must exceed the threshold too
  task automatic test_behind();
    write_reg(REG_BLEND_MODE, 32'(MODE_BEHIND));
    send_pixel(make_pixel(8'h33, 8'h80, 8'hC4, 8'hC8, 8'hFF, 1'b0));
    send_pixel(make_pixel(8'h33, 8'h7F, 8'hC4, 8'hFF, 8'hFF, 1'b1));
  endtask

  // replace: any nonzero coverage, smallest mask on both sides of zero
  task automatic test_replace();
    write_reg(REG_BLEND_MODE, 32'(MODE_REPLACE));
    send_pixel(make_pixel(8'h01, 8'h02, 8'hFE, 8'h55, 8'h00, 1'b0));
    send_pixel(make_pixel(8'h01, 8'h02, 8'hFE, 8'h55, 8'h01, 1'b1));
  endtask

  task automatic test_erase_modes();
    write_reg(REG_BLEND_MODE, 32'(MODE_ERASE));
    send_pixel(make_pixel(8'h9C, 8'hE0, 8'h11, 8'hFF, 8'hFF, 1'b0));
    send_pixel(make_pixel(8'h9C, 8'hE0, 8'h11, 8'h00, 8'hFF, 1'b1));
    write_reg(REG_BLEND_MODE, 32'(MODE_ANTI_ERASE));
    send_pixel(make_pixel(8'h9C, 8'h10, 8'h11, 8'hFF, 8'hFF, 1'b0));
  endtask

  // undefined mode code and out-of-range write data, only low bits kept
  task automatic test_undefined_mode();
    write_reg(REG_BLEND_MODE, 32'hFFFF_FFFF);
    send_pixel(make_pixel(8'h20, 8'h30, 8'h40, 8'hFF, 8'hFF, 1'b1));
    write_reg(REG_LAYER_OPACITY, 32'h0000_0100);
    send_pixel(make_pixel(8'h20, 8'h30, 8'h40, 8'hFF, 8'hFF, 1'b0));
    restore_defaults();
  endtask

  // neither pixel carries alpha
  task automatic test_missing_alpha();
    write_reg(REG_MASK_PRESENT, 32'h1);
    write_reg(REG_BASE_HAS_ALPHA, 32'h0);
    write_reg(REG_LAYER_HAS_ALPHA, 32'h0);
    send_pixel(make_pixel(8'h5A, 8'h5A, 8'hA5, 8'h00, 8'hC8, 1'b0));
    write_reg(REG_BLEND_MODE, 32'(MODE_ERASE));
    send_pixel(make_pixel(8'h5A, 8'hFF, 8'hA5, 8'h00, 8'hFF, 1'b1));
    write_reg(REG_BLEND_MODE, 32'(MODE_BEHIND));
    send_pixel(make_pixel(8'h5A, 8'h00, 8'hA5, 8'h00, 8'hFF, 1'b0));
  endtask

  // both affect bits clear block every write in normal and replace mode
  task automatic test_affect_off();
    restore_defaults();
    write_reg(REG_AFFECT_INDEX, 32'hFFFF_FFFE);
    write_reg(REG_ALPHA_WR_EN, 32'h0);
    send_pixel(make_pixel(8'h77, 8'h66, 8'h88, 8'hFF, 8'h00, 1'b1));
    write_reg(REG_BLEND_MODE, 32'(MODE_REPLACE));
    send_pixel(make_pixel(8'h77, 8'h66, 8'h88, 8'h99, 8'h00, 1'b0));
  endtask

  // write past the register list changes nothing
  task automatic test_unmapped_register();
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    send_pixel(make_pixel(8'h01, 8'hFE, 8'hFE, 8'h01, 8'hFF, 1'b1));
    restore_defaults();
  endtask

  // long output hold-off while items keep coming, then a full drain
  task automatic test_output_hold();
    set_idling(0, 0);
    @(posedge clk);
    hold_cycles = 120;
    @(negedge clk);
    repeat (30) send_pixel(random_pixel());
    wait_idle();
  endtask

  task automatic randomize_config();
    logic [2:0] mode;
    logic [7:0] opacity;
    mode    = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    opacity = $urandom_range(1) ? EDGE_BYTES[$urandom_range(5)] : pick_byte();
    write_reg(REG_BLEND_MODE, 32'({$urandom, mode}));
    write_reg(REG_LAYER_OPACITY, 32'({$urandom, opacity}));
    write_reg(REG_AFFECT_INDEX, 32'($urandom_range(3) != 0));
    write_reg(REG_ALPHA_WR_EN, 32'($urandom_range(3) != 0));
    write_reg(REG_BASE_HAS_ALPHA, 32'($urandom_range(3) != 0));
    write_reg(REG_LAYER_HAS_ALPHA, 32'($urandom_range(3) != 0));
    write_reg(REG_MASK_PRESENT, $urandom_range(1));
  endtask

  // random items under random settings in each idling pattern
  task automatic test_random_traffic();
    int send_pct [4] = '{0, 75, 0, 15};
    int recv_pct [4] = '{0, 0, 75, 15};
    for (int ph = 0; ph < 4; ph++) begin
      set_idling(send_pct[ph], recv_pct[ph]);
      for (int k = 0; k < 5; k++) begin
        randomize_config();
        repeat (50) send_pixel(random_pixel());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_normal_masked();
    test_behind();
    test_replace();
    test_erase_modes();
    test_undefined_mode();
    test_missing_alpha();
    test_affect_off();
    test_unmapped_register();
    test_output_hold();
    test_random_traffic();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("indexed_pixel_layer_compositor_core verification clean");
    end else begin
      $display("indexed_pixel_layer_compositor_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
